// File: sv/apdf_pkg.sv
package apdf_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_STATE_BITS  = 32;
    localparam int COEF_BITS       = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int PHASE_BITS      = 2;
    localparam int NUM_STATES      = 4;

    localparam logic [COEF_BITS-1:0] COEF_ODD_RESET  = COEF_BITS'(8082);
    localparam logic [COEF_BITS-1:0] COEF_EVEN_RESET = COEF_BITS'(16535);

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ODD  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_EVEN = CFG_INDEX_BITS'(1);

    // Last phase of a group of four: this item produces the output
    localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(3);

    // Allpass state slots
    localparam logic [1:0] SLOT_A_EVEN = 2'd0;
    localparam logic [1:0] SLOT_A_ODD  = 2'd1;
    localparam logic [1:0] SLOT_B_EVEN = 2'd2;
    localparam logic [1:0] SLOT_B_ODD  = 2'd3;

    typedef enum logic [2:0] {
        OPD_X,
        OPD_S,
        OPD_T,
        OPD_P,
        OPD_O,
        OPD_HB,
        OPD_HP,
        OPD_PAIR
    } opd_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_T,
        DST_S,
        DST_O,
        DST_HB,
        DST_HP,
        DST_PAIR
    } dst_t;

    typedef enum logic [4:0] {
        CS_IDLE,
        CS_A_E1, CS_A_E2, CS_A_E3, CS_A_E4,
        CS_A_O1, CS_A_O2, CS_A_O3, CS_A_O4,
        CS_A_SUM,
        CS_B_E1, CS_B_E2, CS_B_E3, CS_B_E4,
        CS_B_O1, CS_B_O2, CS_B_O3, CS_B_O4,
        CS_B_SUM,
        CS_EMIT
    } ctl_state_t;

    typedef struct packed {
        opd_t       a_sel;
        opd_t       b_sel;
        logic       sub;
        dst_t       dst;
        logic [1:0] slot;
        logic       mul_en;
        logic       mul_even;
        logic       load_x;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam dp_cmd_t CMD_NOP = '{
        a_sel:    OPD_X,
        b_sel:    OPD_X,
        sub:      1'b0,
        dst:      DST_NONE,
        slot:     SLOT_A_EVEN,
        mul_en:   1'b0,
        mul_even: 1'b0,
        load_x:   1'b0,
        emit:     1'b0
    };

endpackage

// File: sv/apdf_in_if.sv
interface apdf_in_if
    import apdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// File: sv/apdf_out_if.sv
interface apdf_out_if
    import apdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: sv/apdf_cfg_if.sv
interface apdf_cfg_if
    import apdf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COEF_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/allpass_decimate_by_four_unit.sv
// Sequential core: one saturating adder and one multiplier, stepped one operation per cycle
// except while the emit state waits for a free output register. Per item: phases 0 and 2
// run stage one's even branch, phase 1 its odd branch and pair sum, and phase 3 both stages.
// The result is loaded into the output register from the emit state after stage two's sum.
// The output register lets the next item in while a result waits.
// Reset clears the control, phase and filter states and restores the default coefficients.
module allpass_decimate_by_four_unit
    import apdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int STATE_BITS  = DEF_STATE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    apdf_in_if.sink   din,
    apdf_out_if.source dout,
    apdf_cfg_if.sink  cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    apdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    apdf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (din.sample_in),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .out_data  (dout.sample_out),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .status    (status)
    );

    // A result is only loaded when the output register is free or being drained
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!dout.valid || dout.ready))
        else $error("result loaded over an untaken item");

    // Every multiply uses a difference written in the cycle before
    a_mul_after_t: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_en |-> $past(cmd.dst == DST_T))
        else $error("multiply without a fresh difference");

    // Datapath stays quiet while an item is being taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        din.ready |-> (cmd.dst == DST_NONE && !cmd.mul_en && !cmd.emit))
        else $error("datapath busy while accepting");

endmodule

// File: sv/apdf_ctrl.sv
module apdf_ctrl
    import apdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t            state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = phase_reg[0] ? CS_A_O1 : CS_A_E1;
                end
            end
            CS_A_E1:  state_next = CS_A_E2;
            CS_A_E2:  state_next = CS_A_E3;
            CS_A_E3:  state_next = CS_A_E4;
            CS_A_E4:  state_next = CS_IDLE;
            CS_A_O1:  state_next = CS_A_O2;
            CS_A_O2:  state_next = CS_A_O3;
            CS_A_O3:  state_next = CS_A_O4;
            CS_A_O4:  state_next = CS_A_SUM;
            CS_A_SUM: state_next = (phase_reg == PHASE_LAST) ? CS_B_E1 : CS_IDLE;
            CS_B_E1:  state_next = CS_B_E2;
            CS_B_E2:  state_next = CS_B_E3;
            CS_B_E3:  state_next = CS_B_E4;
            CS_B_E4:  state_next = CS_B_O1;
            CS_B_O1:  state_next = CS_B_O2;
            CS_B_O2:  state_next = CS_B_O3;
            CS_B_O3:  state_next = CS_B_O4;
            CS_B_O4:  state_next = CS_B_SUM;
            CS_B_SUM: state_next = CS_EMIT;
            CS_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:  state_next = CS_IDLE;
        endcase
    end

    // Advance the phase once the item in flight is finished
    always_comb
    begin
        phase_next = phase_reg;
        if (state_reg != CS_IDLE && state_next == CS_IDLE)
        begin
            phase_next = phase_reg + PHASE_BITS'(1);
        end
    end

    always_comb
    begin
        cmd      = CMD_NOP;
        in_ready = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.load_x = in_valid;
            end
            // stage one, even branch: t = s - x; s = c*t - s; out = s - t
            CS_A_E1:
            begin
                cmd.a_sel = OPD_S;  cmd.b_sel = OPD_X;  cmd.sub = 1'b1;
                cmd.dst   = DST_T;  cmd.slot  = SLOT_A_EVEN;
            end
            CS_A_E2:
            begin
                cmd.mul_en = 1'b1;  cmd.mul_even = 1'b1;
            end
            CS_A_E3:
            begin
                cmd.a_sel = OPD_P;  cmd.b_sel = OPD_S;  cmd.sub = 1'b1;
                cmd.dst   = DST_S;  cmd.slot  = SLOT_A_EVEN;
            end
            CS_A_E4:
            begin
                cmd.a_sel = OPD_S;  cmd.b_sel = OPD_T;  cmd.sub = 1'b1;
                cmd.dst   = DST_HB; cmd.slot  = SLOT_A_EVEN;
            end
            // stage one, odd branch: t = x - s; out = c*t - s; s = out - t
            CS_A_O1:
            begin
                cmd.a_sel = OPD_X;  cmd.b_sel = OPD_S;  cmd.sub = 1'b1;
                cmd.dst   = DST_T;  cmd.slot  = SLOT_A_ODD;
            end
            CS_A_O2:
            begin
                cmd.mul_en = 1'b1;
            end
            CS_A_O3:
            begin
                cmd.a_sel = OPD_P;  cmd.b_sel = OPD_S;  cmd.sub = 1'b1;
                cmd.dst   = DST_O;  cmd.slot  = SLOT_A_ODD;
            end
            CS_A_O4:
            begin
                cmd.a_sel = OPD_O;  cmd.b_sel = OPD_T;  cmd.sub = 1'b1;
                cmd.dst   = DST_S;  cmd.slot  = SLOT_A_ODD;
            end
            CS_A_SUM:
            begin
                cmd.a_sel = OPD_O;  cmd.b_sel = OPD_HB;
                cmd.dst   = (phase_reg == PHASE_LAST) ? DST_PAIR : DST_HP;
            end
            CS_B_E1:
            begin
                cmd.a_sel = OPD_S;  cmd.b_sel = OPD_HP; cmd.sub = 1'b1;
                cmd.dst   = DST_T;  cmd.slot  = SLOT_B_EVEN;
            end
            CS_B_E2:
            begin
                cmd.mul_en = 1'b1;  cmd.mul_even = 1'b1;
            end
            CS_B_E3:
            begin
                cmd.a_sel = OPD_P;  cmd.b_sel = OPD_S;  cmd.sub = 1'b1;
                cmd.dst   = DST_S;  cmd.slot  = SLOT_B_EVEN;
            end
            CS_B_E4:
            begin
                // stage one's even output is spent by its pair sum, so this branch output may reuse the hold register
                cmd.a_sel = OPD_S;  cmd.b_sel = OPD_T;  cmd.sub = 1'b1;
                cmd.dst   = DST_HB; cmd.slot  = SLOT_B_EVEN;
            end
            CS_B_O1:
            begin
                cmd.a_sel = OPD_PAIR; cmd.b_sel = OPD_S; cmd.sub = 1'b1;
                cmd.dst   = DST_T;    cmd.slot  = SLOT_B_ODD;
            end
            CS_B_O2:
            begin
                cmd.mul_en = 1'b1;
            end
            CS_B_O3:
            begin
                cmd.a_sel = OPD_P;  cmd.b_sel = OPD_S;  cmd.sub = 1'b1;
                cmd.dst   = DST_O;  cmd.slot  = SLOT_B_ODD;
            end
            CS_B_O4:
            begin
                cmd.a_sel = OPD_O;  cmd.b_sel = OPD_T;  cmd.sub = 1'b1;
                cmd.dst   = DST_S;  cmd.slot  = SLOT_B_ODD;
            end
            CS_B_SUM:
            begin
                cmd.a_sel = OPD_O;  cmd.b_sel = OPD_HB;
                cmd.dst   = DST_PAIR;
            end
            CS_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = CMD_NOP;
            end
        endcase
    end

endmodule

// File: sv/apdf_datapath.sv
module apdf_datapath
    import apdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int STATE_BITS  = DEF_STATE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_data,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status
);

    localparam int SB    = SAMPLE_BITS;
    localparam int WB    = STATE_BITS;
    localparam int EXTRA = WB - SB;
    localparam int LX    = (EXTRA > 0) ? EXTRA : 0;
    localparam int RX    = (EXTRA < 0) ? -EXTRA : 0;
    localparam int XW    = SB + LX;
    localparam int OSH   = EXTRA + 2;
    localparam int LSH   = (OSH < 0) ? -OSH : 0;
    localparam int RSH   = (OSH > 0) ? OSH : 0;
    localparam int ZW    = (WB + LSH > SB) ? WB + LSH : SB;
    localparam int PW    = WB + COEF_BITS + 1;

    localparam logic signed [WB-1:0] ST_MAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] ST_MIN = {1'b1, {(WB-1){1'b0}}};
    localparam logic signed [SB-1:0] SM_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SM_MIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [WB-1:0] x_reg, x_next;
    logic signed [WB-1:0] t_reg, t_next;
    logic signed [WB-1:0] p_reg, p_next;
    logic signed [WB-1:0] o_reg, o_next;
    logic signed [WB-1:0] hb_reg, hb_next;
    logic signed [WB-1:0] hp_reg, hp_next;
    logic signed [WB-1:0] pair_reg, pair_next;
    logic signed [WB-1:0] st_reg [NUM_STATES];
    logic signed [WB-1:0] st_next [NUM_STATES];
    logic [COEF_BITS-1:0] coef_odd_reg, coef_odd_next;
    logic [COEF_BITS-1:0] coef_even_reg, coef_even_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [SB-1:0] out_data_reg, out_data_next;

    logic signed [XW-1:0] x_ext, x_shift;
    logic signed [WB-1:0] x_wide;
    logic signed [WB-1:0] s_val, a_val, b_val, alu_res;
    logic signed [WB:0]   a_x, b_x, sum;
    logic [COEF_BITS-1:0] coef_sel;
    logic signed [PW-1:0] prod;
    logic signed [ZW-1:0] y_ext, y_shift;
    logic                 y_fits;
    logic signed [SB-1:0] y_sat;

    // Sample into state format
    assign x_ext   = XW'(sample_in);
    assign x_shift = (x_ext <<< LX) >>> RX;
    assign x_wide  = WB'(x_shift);

    assign s_val = st_reg[cmd.slot];

    always_comb
    begin
        case (cmd.a_sel)
            OPD_X:    a_val = x_reg;
            OPD_S:    a_val = s_val;
            OPD_T:    a_val = t_reg;
            OPD_P:    a_val = p_reg;
            OPD_O:    a_val = o_reg;
            OPD_HB:   a_val = hb_reg;
            OPD_HP:   a_val = hp_reg;
            OPD_PAIR: a_val = pair_reg;
            default:  a_val = x_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            OPD_X:    b_val = x_reg;
            OPD_S:    b_val = s_val;
            OPD_T:    b_val = t_reg;
            OPD_P:    b_val = p_reg;
            OPD_O:    b_val = o_reg;
            OPD_HB:   b_val = hb_reg;
            OPD_HP:   b_val = hp_reg;
            OPD_PAIR: b_val = pair_reg;
            default:  b_val = x_reg;
        endcase
    end

    // Saturating add/subtract
    assign a_x     = (WB+1)'(a_val);
    assign b_x     = (WB+1)'(b_val);
    assign sum     = cmd.sub ? (a_x - b_x) : (a_x + b_x);
    assign alu_res = (sum[WB] == sum[WB-1]) ? sum[WB-1:0] : (sum[WB] ? ST_MIN : ST_MAX);

    // Coefficient product, floor-shifted by the coefficient width; always fits the state
    assign coef_sel = cmd.mul_even ? coef_even_reg : coef_odd_reg;
    assign prod     = PW'(t_reg) * PW'($signed({1'b0, coef_sel}));

    // Divide by four, back to sample format, saturate
    assign y_ext   = ZW'(pair_reg);
    assign y_shift = (y_ext <<< LSH) >>> RSH;
    assign y_fits  = (&y_shift[ZW-1:SB-1]) | ~(|y_shift[ZW-1:SB-1]);
    assign y_sat   = y_fits ? y_shift[SB-1:0] : (y_shift[ZW-1] ? SM_MIN : SM_MAX);

    always_comb
    begin
        x_next         = x_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        o_next         = o_reg;
        hb_next        = hb_reg;
        hp_next        = hp_reg;
        pair_next      = pair_reg;
        st_next        = st_reg;
        coef_odd_next  = coef_odd_reg;
        coef_even_next = coef_even_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.load_x)
        begin
            x_next = x_wide;
        end
        if (cmd.mul_en)
        begin
            p_next = prod[WB+COEF_BITS-1:COEF_BITS];
        end

        case (cmd.dst)
            DST_NONE: ;
            DST_T:    t_next = alu_res;
            DST_S:    st_next[cmd.slot] = alu_res;
            DST_O:    o_next = alu_res;
            DST_HB:   hb_next = alu_res;
            DST_HP:   hp_next = alu_res;
            DST_PAIR: pair_next = alu_res;
            default:  ;
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_ODD:  coef_odd_next = cfg_data;
                REG_COEF_EVEN: coef_even_next = cfg_data;
                default:       ;
            endcase
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = y_sat;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg        <= '0;
            hp_reg        <= '0;
            coef_odd_reg  <= COEF_ODD_RESET;
            coef_even_reg <= COEF_EVEN_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            hb_reg        <= hb_next;
            hp_reg        <= hp_next;
            coef_odd_reg  <= coef_odd_next;
            coef_even_reg <= coef_even_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        o_reg        <= o_next;
        pair_reg     <= pair_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule
